// ----- rtl/pmftl_pkg.sv -----
package pmftl_pkg;

  // Geometry
  localparam int NumBlocks      = 64;
  localparam int BlkW           = $clog2(NumBlocks);
  localparam int BlkIdW         = BlkW + 1;
  localparam int PagesPerBlock  = 16;
  localparam int SlotW          = $clog2(PagesPerBlock);
  localparam int FillW          = SlotW + 1;
  localparam int NumStreams     = 4;
  localparam int StrW           = $clog2(NumStreams);
  localparam int PagesPerStream = 1024;
  localparam int PageW          = $clog2(PagesPerStream);
  localparam int KeyW           = StrW + PageW;
  localparam int LocW           = BlkW + SlotW;
  localparam int MapW           = LocW + 1;

  // Field and counter widths
  localparam int EraseW  = 32;
  localparam int TsW     = 64;
  localparam int CntW    = 48;
  localparam int UseW    = BlkIdW;
  localparam int RelW    = 10;
  localparam int ErsW    = 6;
  localparam int LimitW  = 6;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(56);
  localparam logic [BlkIdW-1:0] NoBlock    = BlkIdW'(NumBlocks);

  // Result status codes
  localparam logic StatusOk        = 1'b0;
  localparam logic StatusExhausted = 1'b1;

  // Command codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdTrim  = 1'b1;

  // Per-block bookkeeping, one memory word per block
  typedef struct packed {
    logic              in_use;
    logic [TsW-1:0]    last;
    logic [EraseW-1:0] erase;
    logic [StrW-1:0]   owner;
    logic [FillW-1:0]  live;
    logic [FillW-1:0]  fill;
  } meta_t;

  localparam int MetaW = $bits(meta_t);

  // Running best of a block scan, handed to the compare unit
  typedef struct packed {
    logic              free_mode;
    logic              best_vld;
    logic [FillW-1:0]  best_live;
    logic [TsW-1:0]    best_last;
    logic [EraseW-1:0] best_erase;
  } cmp_req_t;

endpackage

// ----- rtl/pmftl_if.sv -----
interface pmftl_req_if import pmftl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [StrW-1:0]  stream;
  logic [PageW-1:0] logical_page;
  logic [TsW-1:0]   timestamp;

  modport source (output valid, cmd, stream, logical_page, timestamp, input ready);
  modport sink (input valid, cmd, stream, logical_page, timestamp, output ready);
endinterface

interface pmftl_rsp_if import pmftl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [BlkW-1:0]  placed_block;
  logic [SlotW-1:0] placed_slot;
  logic             old_copy_dropped;
  logic [RelW-1:0]  pages_relocated;
  logic [ErsW-1:0]  blocks_erased;
  logic [CntW-1:0]  host_program_total;
  logic [CntW-1:0]  relocation_program_total;
  logic [CntW-1:0]  erase_total;

  modport source (output valid, status, placed_block, placed_slot, old_copy_dropped,
                  pages_relocated, blocks_erased, host_program_total,
                  relocation_program_total, erase_total, input ready);
  modport sink (input valid, status, placed_block, placed_slot, old_copy_dropped,
                pages_relocated, blocks_erased, host_program_total,
                relocation_program_total, erase_total, output ready);
endinterface

interface pmftl_cfg_if import pmftl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LimitW-1:0] active_limit;

  modport source (output valid, active_limit, input ready);
  modport sink (input valid, active_limit, output ready);
endinterface

// ----- rtl/pmftl_ram.sv -----
module pmftl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/pmftl_meta.sv -----
module pmftl_meta import pmftl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [BlkW-1:0] waddr_i,
  input  meta_t           wdata_i,
  input  logic [BlkW-1:0] raddr_i,
  output meta_t           rdata_o
);

  logic [NumBlocks-1:0] vld_q;
  logic                 rvld_q;
  logic [MetaW-1:0]     ram_rdata;

  pmftl_ram #(.Width(MetaW), .Depth(NumBlocks)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // Track written entries; an unwritten block reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? meta_t'(ram_rdata) : '0;

endmodule

// ----- rtl/pmftl_cmp.sv -----
module pmftl_cmp import pmftl_pkg::*; (
  input  cmp_req_t req_i,
  input  meta_t    cand_i,
  output logic     take_o
);

  logic elig;
  logic less;

  // Free pick: fewest erases. Victim pick: fewest live, oldest, fewest erases.
  always_comb begin
    if (req_i.free_mode) begin
      elig = !cand_i.in_use;
      less = cand_i.erase < req_i.best_erase;
    end else begin
      elig = cand_i.in_use && (cand_i.fill == FillW'(PagesPerBlock)) &&
             (cand_i.live != FillW'(PagesPerBlock));
      less = (cand_i.live < req_i.best_live) ||
             ((cand_i.live == req_i.best_live) &&
              ((cand_i.last < req_i.best_last) ||
               ((cand_i.last == req_i.best_last) && (cand_i.erase < req_i.best_erase))));
    end
    take_o = elig && (!req_i.best_vld || less);
  end

endmodule

// ----- rtl/page_mapped_ftl_greedy_gc_unit.sv -----
// Channel  Modport          Moves
// cfg_i    pmftl_cfg_if     active_limit register write, always ready
// req_i    pmftl_req_if     one command item (write or trim of a page)
// rsp_o    pmftl_rsp_if     one result item per command
//
// After reset the page map is swept clear; no item is taken then.
// A trim goes from map lookup to result; a write to an open frontier also programs a page there.
// Opening a block adds a free-block scan; each collection adds a victim scan, a read of
// every victim slot plus a program per relocated page, and an erase, all
// through the one block metadata read port and the shared compare unit.
// One item is worked at a time; the next is taken once the result is in the output register.
module page_mapped_ftl_greedy_gc_unit import pmftl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  pmftl_cfg_if.sink    cfg_i,
  pmftl_req_if.sink    req_i,
  pmftl_rsp_if.source  rsp_o
);

  localparam int StW = 5;
  localparam logic [StW-1:0] ST_CLEAR    = 5'd0;
  localparam logic [StW-1:0] ST_IDLE     = 5'd1;
  localparam logic [StW-1:0] ST_MAP      = 5'd2;
  localparam logic [StW-1:0] ST_DROP     = 5'd3;
  localparam logic [StW-1:0] ST_HOST     = 5'd4;
  localparam logic [StW-1:0] ST_LOOP     = 5'd5;
  localparam logic [StW-1:0] ST_SECOND   = 5'd6;
  localparam logic [StW-1:0] ST_OPEN     = 5'd7;
  localparam logic [StW-1:0] ST_SCAN     = 5'd8;
  localparam logic [StW-1:0] ST_SCAN_END = 5'd9;
  localparam logic [StW-1:0] ST_VFIT     = 5'd10;
  localparam logic [StW-1:0] ST_RS_ISSUE = 5'd11;
  localparam logic [StW-1:0] ST_RS_DATA  = 5'd12;
  localparam logic [StW-1:0] ST_APP_RD   = 5'd13;
  localparam logic [StW-1:0] ST_APP      = 5'd14;
  localparam logic [StW-1:0] ST_ERASE_RD = 5'd15;
  localparam logic [StW-1:0] ST_ERASE    = 5'd16;
  localparam logic [StW-1:0] ST_OUT      = 5'd17;

  // Control state
  logic [StW-1:0]    state_q, state_d;
  logic [KeyW-1:0]   clr_q, clr_d;
  logic [LimitW-1:0] limit_q, limit_d;
  logic [UseW-1:0]   use_cnt_q, use_cnt_d;
  logic [CntW-1:0]   host_cnt_q, host_cnt_d;
  logic [CntW-1:0]   rel_cnt_q, rel_cnt_d;
  logic [CntW-1:0]   ers_cnt_q, ers_cnt_d;
  logic [BlkIdW-1:0] frontier_q [NumStreams];
  logic [BlkIdW-1:0] scan_q, scan_d;
  logic [FillW-1:0]  slot_q, slot_d;
  logic              best_vld_q, best_vld_d;
  logic              free_mode_q, free_mode_d;
  logic              col_second_q, col_second_d;
  logic              open_rel_q, open_rel_d;
  logic              app_rel_q, app_rel_d;
  logic              out_vld_q, out_vld_d;

  // Item payload
  logic              cmd_q, cmd_d;
  logic [StrW-1:0]   st_q, st_d;
  logic [PageW-1:0]  page_q, page_d;
  logic [TsW-1:0]    ts_q, ts_d;
  logic              dropped_q, dropped_d;
  logic              status_q, status_d;
  logic [BlkW-1:0]   pb_q, pb_d;
  logic [SlotW-1:0]  ps_q, ps_d;
  logic [RelW-1:0]   rel_q, rel_d;
  logic [ErsW-1:0]   ers_q, ers_d;
  logic [BlkW-1:0]   fblk_q, fblk_d;
  logic [BlkW-1:0]   db_q, db_d;
  logic [BlkW-1:0]   best_idx_q, best_idx_d;
  logic [FillW-1:0]  best_live_q, best_live_d;
  logic [TsW-1:0]    best_last_q, best_last_d;
  logic [EraseW-1:0] best_erase_q, best_erase_d;
  logic [StrW-1:0]   best_owner_q, best_owner_d;
  logic [BlkW-1:0]   vic_q, vic_d;
  logic [StrW-1:0]   vst_q, vst_d;
  logic [FillW-1:0]  vlive_q, vlive_d;
  logic [KeyW-1:0]   rkey_q, rkey_d;

  // Output register
  logic              o_status_q;
  logic [BlkW-1:0]   o_pb_q;
  logic [SlotW-1:0]  o_ps_q;
  logic              o_dropped_q;
  logic [RelW-1:0]   o_rel_q;
  logic [ErsW-1:0]   o_ers_q;
  logic [CntW-1:0]   o_host_q;
  logic [CntW-1:0]   o_relp_q;
  logic [CntW-1:0]   o_erase_q;
  logic              out_load;

  // Frontier table port
  logic [StrW-1:0]   fr_raddr;
  logic [BlkIdW-1:0] fr_rd;
  logic              fr_we;
  logic [StrW-1:0]   fr_waddr;
  logic [BlkIdW-1:0] fr_wdata;

  // Memory ports
  logic              pm_we;
  logic [KeyW-1:0]   pm_waddr, pm_raddr;
  logic [MapW-1:0]   pm_wdata, pm_rdata;
  logic              sl_we;
  logic [LocW-1:0]   sl_waddr, sl_raddr;
  logic [KeyW:0]     sl_wdata, sl_rdata;
  logic              mt_we;
  logic [BlkW-1:0]   mt_waddr, mt_raddr;
  meta_t             mt_wdata, mt_rdata;

  // Compare unit
  cmp_req_t          cmp_req;
  logic              take;

  // Derived values
  logic [KeyW-1:0]   key;
  logic [KeyW-1:0]   akey;
  logic [LocW-1:0]   drop_loc;
  logic [LocW-1:0]   app_loc;
  logic [StrW-1:0]   ostr;
  logic [BlkW-1:0]   eval_idx;
  logic              req_fire;

  assign key      = {st_q, page_q};
  assign akey     = app_rel_q ? rkey_q : key;
  assign drop_loc = LocW'(pm_rdata - MapW'(1));
  assign app_loc  = {fblk_q, mt_rdata.fill[SlotW-1:0]};
  assign ostr     = open_rel_q ? vst_q : st_q;
  assign eval_idx = BlkW'(scan_q - BlkIdW'(1));
  assign fr_rd    = frontier_q[fr_raddr];
  assign req_fire = req_i.valid && req_i.ready;

  assign cmp_req.free_mode  = free_mode_q;
  assign cmp_req.best_vld   = best_vld_q;
  assign cmp_req.best_live  = best_live_q;
  assign cmp_req.best_last  = best_last_q;
  assign cmp_req.best_erase = best_erase_q;

  pmftl_ram #(.Width(MapW), .Depth(NumStreams * PagesPerStream)) u_page_map (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  pmftl_ram #(.Width(KeyW + 1), .Depth(NumBlocks * PagesPerBlock)) u_slot_owner (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (sl_wdata),
    .raddr_i (sl_raddr),
    .rdata_o (sl_rdata)
  );

  pmftl_meta u_meta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mt_we),
    .waddr_i (mt_waddr),
    .wdata_i (mt_wdata),
    .raddr_i (mt_raddr),
    .rdata_o (mt_rdata)
  );

  pmftl_cmp u_cmp (
    .req_i  (cmp_req),
    .cand_i (mt_rdata),
    .take_o (take)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid                    = out_vld_q;
  assign rsp_o.status                   = o_status_q;
  assign rsp_o.placed_block             = o_pb_q;
  assign rsp_o.placed_slot              = o_ps_q;
  assign rsp_o.old_copy_dropped         = o_dropped_q;
  assign rsp_o.pages_relocated          = o_rel_q;
  assign rsp_o.blocks_erased            = o_ers_q;
  assign rsp_o.host_program_total       = o_host_q;
  assign rsp_o.relocation_program_total = o_relp_q;
  assign rsp_o.erase_total              = o_erase_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    limit_d      = limit_q;
    use_cnt_d    = use_cnt_q;
    host_cnt_d   = host_cnt_q;
    rel_cnt_d    = rel_cnt_q;
    ers_cnt_d    = ers_cnt_q;
    scan_d       = scan_q;
    slot_d       = slot_q;
    best_vld_d   = best_vld_q;
    free_mode_d  = free_mode_q;
    col_second_d = col_second_q;
    open_rel_d   = open_rel_q;
    app_rel_d    = app_rel_q;
    out_vld_d    = out_vld_q && !rsp_o.ready;
    out_load     = 1'b0;
    cmd_d        = cmd_q;
    st_d         = st_q;
    page_d       = page_q;
    ts_d         = ts_q;
    dropped_d    = dropped_q;
    status_d     = status_q;
    pb_d         = pb_q;
    ps_d         = ps_q;
    rel_d        = rel_q;
    ers_d        = ers_q;
    fblk_d       = fblk_q;
    db_d         = db_q;
    best_idx_d   = best_idx_q;
    best_live_d  = best_live_q;
    best_last_d  = best_last_q;
    best_erase_d = best_erase_q;
    best_owner_d = best_owner_q;
    vic_d        = vic_q;
    vst_d        = vst_q;
    vlive_d      = vlive_q;
    rkey_d       = rkey_q;

    fr_raddr = st_q;
    fr_we    = 1'b0;
    fr_waddr = ostr;
    fr_wdata = NoBlock;

    pm_we    = 1'b0;
    pm_waddr = akey;
    pm_wdata = '0;
    pm_raddr = {req_i.stream, req_i.logical_page};
    sl_we    = 1'b0;
    sl_waddr = app_loc;
    sl_wdata = '0;
    sl_raddr = {vic_q, slot_q[SlotW-1:0]};
    mt_we    = 1'b0;
    mt_waddr = fblk_q;
    mt_wdata = mt_rdata;
    mt_raddr = scan_q[BlkW-1:0];

    // Take the limit register
    if (cfg_i.valid) begin
      limit_d = cfg_i.active_limit;
    end

    case (state_q)
      // Sweep the page map to unmapped
      ST_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_q;
        pm_wdata = '0;
        clr_d    = clr_q + KeyW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      // Latch the item and look up its mapping
      ST_IDLE: begin
        if (req_fire) begin
          cmd_d     = req_i.cmd;
          st_d      = req_i.stream;
          page_d    = req_i.logical_page;
          ts_d      = req_i.timestamp;
          dropped_d = 1'b0;
          status_d  = StatusOk;
          pb_d      = '0;
          ps_d      = '0;
          rel_d     = '0;
          ers_d     = '0;
          state_d   = ST_MAP;
        end
      end

      // Drop the old copy if mapped
      ST_MAP: begin
        if (pm_rdata != '0) begin
          pm_we     = 1'b1;
          pm_waddr  = key;
          pm_wdata  = '0;
          sl_we     = 1'b1;
          sl_waddr  = drop_loc;
          sl_wdata  = '0;
          mt_raddr  = drop_loc[LocW-1:SlotW];
          db_d      = drop_loc[LocW-1:SlotW];
          dropped_d = 1'b1;
          state_d   = ST_DROP;
        end else begin
          state_d = ST_HOST;
        end
      end

      ST_DROP: begin
        if (mt_rdata.live != '0) begin
          mt_we         = 1'b1;
          mt_waddr      = db_q;
          mt_wdata      = mt_rdata;
          mt_wdata.live = mt_rdata.live - FillW'(1);
        end
        state_d = ST_HOST;
      end

      ST_HOST: begin
        if (cmd_q == CmdTrim) begin
          state_d = ST_OUT;
        end else if (fr_rd != NoBlock) begin
          fblk_d    = fr_rd[BlkW-1:0];
          app_rel_d = 1'b0;
          state_d   = ST_APP_RD;
        end else begin
          state_d = ST_LOOP;
        end
      end

      // Collect while at or above the active limit
      ST_LOOP: begin
        if (use_cnt_q >= UseW'(limit_q)) begin
          col_second_d = 1'b0;
          free_mode_d  = 1'b0;
          best_vld_d   = 1'b0;
          scan_d       = '0;
          state_d      = ST_SCAN;
        end else begin
          state_d = ST_SECOND;
        end
      end

      // One more try when nothing is free
      ST_SECOND: begin
        if (use_cnt_q >= UseW'(NumBlocks)) begin
          col_second_d = 1'b1;
          free_mode_d  = 1'b0;
          best_vld_d   = 1'b0;
          scan_d       = '0;
          state_d      = ST_SCAN;
        end else begin
          state_d = ST_OPEN;
        end
      end

      ST_OPEN: begin
        open_rel_d  = 1'b0;
        free_mode_d = 1'b1;
        best_vld_d  = 1'b0;
        scan_d      = '0;
        state_d     = ST_SCAN;
      end

      // Read block i, judge block i-1
      ST_SCAN: begin
        mt_raddr = scan_q[BlkW-1:0];
        if ((scan_q != '0) && take) begin
          best_vld_d   = 1'b1;
          best_idx_d   = eval_idx;
          best_live_d  = mt_rdata.live;
          best_last_d  = mt_rdata.last;
          best_erase_d = mt_rdata.erase;
          best_owner_d = mt_rdata.owner;
        end
        if (scan_q == NoBlock) begin
          state_d = ST_SCAN_END;
        end else begin
          scan_d = scan_q + BlkIdW'(1);
        end
      end

      ST_SCAN_END: begin
        fr_raddr = best_owner_q;
        if (free_mode_q) begin
          if (best_vld_q) begin
            // Open the chosen block as the stream's frontier
            mt_we           = 1'b1;
            mt_waddr        = best_idx_q;
            mt_wdata.fill   = '0;
            mt_wdata.live   = '0;
            mt_wdata.owner  = ostr;
            mt_wdata.erase  = best_erase_q;
            mt_wdata.last   = ts_q;
            mt_wdata.in_use = 1'b1;
            use_cnt_d       = use_cnt_q + UseW'(1);
            fr_we           = 1'b1;
            fr_waddr        = ostr;
            fr_wdata        = BlkIdW'(best_idx_q);
            fblk_d          = best_idx_q;
            app_rel_d       = open_rel_q;
            state_d         = ST_APP_RD;
          end else if (open_rel_q) begin
            state_d = ST_ERASE_RD;
          end else begin
            status_d = StatusExhausted;
            state_d  = ST_OUT;
          end
        end else if (!best_vld_q) begin
          state_d = col_second_q ? ST_OPEN : ST_SECOND;
        end else begin
          vic_d   = best_idx_q;
          vst_d   = best_owner_q;
          vlive_d = best_live_q;
          slot_d  = '0;
          if ((use_cnt_q >= UseW'(NumBlocks)) && (best_live_q != '0)) begin
            if (fr_rd == NoBlock) begin
              state_d = col_second_q ? ST_OPEN : ST_SECOND;
            end else begin
              mt_raddr = fr_rd[BlkW-1:0];
              state_d  = ST_VFIT;
            end
          end else begin
            state_d = ST_RS_ISSUE;
          end
        end
      end

      // Refuse when the live pages do not fit the frontier
      ST_VFIT: begin
        if ((FillW'(PagesPerBlock) - mt_rdata.fill) < vlive_q) begin
          state_d = col_second_q ? ST_OPEN : ST_SECOND;
        end else begin
          state_d = ST_RS_ISSUE;
        end
      end

      ST_RS_ISSUE: begin
        sl_raddr = {vic_q, slot_q[SlotW-1:0]};
        if (slot_q == FillW'(PagesPerBlock)) begin
          state_d = ST_ERASE_RD;
        end else begin
          state_d = ST_RS_DATA;
        end
      end

      // Move a live page to the victim stream's frontier
      ST_RS_DATA: begin
        fr_raddr = vst_q;
        slot_d   = slot_q + FillW'(1);
        if (!sl_rdata[0]) begin
          state_d = ST_RS_ISSUE;
        end else begin
          rkey_d = sl_rdata[KeyW:1];
          if (fr_rd != NoBlock) begin
            fblk_d    = fr_rd[BlkW-1:0];
            app_rel_d = 1'b1;
            state_d   = ST_APP_RD;
          end else begin
            open_rel_d  = 1'b1;
            free_mode_d = 1'b1;
            best_vld_d  = 1'b0;
            scan_d      = '0;
            state_d     = ST_SCAN;
          end
        end
      end

      ST_APP_RD: begin
        mt_raddr = fblk_q;
        state_d  = ST_APP;
      end

      // Program one page at the frontier
      ST_APP: begin
        sl_we         = 1'b1;
        sl_waddr      = app_loc;
        sl_wdata      = {akey, 1'b1};
        mt_we         = 1'b1;
        mt_waddr      = fblk_q;
        mt_wdata      = mt_rdata;
        mt_wdata.fill = mt_rdata.fill + FillW'(1);
        mt_wdata.live = mt_rdata.live + FillW'(1);
        mt_wdata.last = ts_q;
        pm_we         = 1'b1;
        pm_waddr      = akey;
        pm_wdata      = MapW'(app_loc) + MapW'(1);
        if ((mt_rdata.fill + FillW'(1)) == FillW'(PagesPerBlock)) begin
          fr_we    = 1'b1;
          fr_waddr = mt_rdata.owner;
          fr_wdata = NoBlock;
        end
        if (app_rel_q) begin
          if (rel_cnt_q != '1) begin
            rel_cnt_d = rel_cnt_q + CntW'(1);
          end
          if (rel_q != '1) begin
            rel_d = rel_q + RelW'(1);
          end
          state_d = ST_RS_ISSUE;
        end else begin
          if (host_cnt_q != '1) begin
            host_cnt_d = host_cnt_q + CntW'(1);
          end
          pb_d    = fblk_q;
          ps_d    = mt_rdata.fill[SlotW-1:0];
          state_d = ST_OUT;
        end
      end

      ST_ERASE_RD: begin
        mt_raddr = vic_q;
        state_d  = ST_ERASE;
      end

      // Erase the victim and close the collection
      ST_ERASE: begin
        mt_we           = 1'b1;
        mt_waddr        = vic_q;
        mt_wdata        = mt_rdata;
        mt_wdata.fill   = '0;
        mt_wdata.live   = '0;
        mt_wdata.in_use = 1'b0;
        if (mt_rdata.erase != '1) begin
          mt_wdata.erase = mt_rdata.erase + EraseW'(1);
        end
        if (ers_cnt_q != '1) begin
          ers_cnt_d = ers_cnt_q + CntW'(1);
        end
        if (use_cnt_q != '0) begin
          use_cnt_d = use_cnt_q - UseW'(1);
        end
        if (ers_q != '1) begin
          ers_d = ers_q + ErsW'(1);
        end
        fr_raddr = st_q;
        if (col_second_q) begin
          state_d = ST_OPEN;
        end else if (fr_rd != NoBlock) begin
          fblk_d    = fr_rd[BlkW-1:0];
          app_rel_d = 1'b0;
          state_d   = ST_APP_RD;
        end else begin
          state_d = ST_LOOP;
        end
      end

      // Hand the result to the output register
      ST_OUT: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      limit_q      <= LimitReset;
      use_cnt_q    <= '0;
      host_cnt_q   <= '0;
      rel_cnt_q    <= '0;
      ers_cnt_q    <= '0;
      scan_q       <= '0;
      slot_q       <= '0;
      best_vld_q   <= 1'b0;
      free_mode_q  <= 1'b0;
      col_second_q <= 1'b0;
      open_rel_q   <= 1'b0;
      app_rel_q    <= 1'b0;
      out_vld_q    <= 1'b0;
      for (int i = 0; i < NumStreams; i++) begin
        frontier_q[i] <= NoBlock;
      end
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      limit_q      <= limit_d;
      use_cnt_q    <= use_cnt_d;
      host_cnt_q   <= host_cnt_d;
      rel_cnt_q    <= rel_cnt_d;
      ers_cnt_q    <= ers_cnt_d;
      scan_q       <= scan_d;
      slot_q       <= slot_d;
      best_vld_q   <= best_vld_d;
      free_mode_q  <= free_mode_d;
      col_second_q <= col_second_d;
      open_rel_q   <= open_rel_d;
      app_rel_q    <= app_rel_d;
      out_vld_q    <= out_vld_d;
      if (fr_we) begin
        frontier_q[fr_waddr] <= fr_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    st_q         <= st_d;
    page_q       <= page_d;
    ts_q         <= ts_d;
    dropped_q    <= dropped_d;
    status_q     <= status_d;
    pb_q         <= pb_d;
    ps_q         <= ps_d;
    rel_q        <= rel_d;
    ers_q        <= ers_d;
    fblk_q       <= fblk_d;
    db_q         <= db_d;
    best_idx_q   <= best_idx_d;
    best_live_q  <= best_live_d;
    best_last_q  <= best_last_d;
    best_erase_q <= best_erase_d;
    best_owner_q <= best_owner_d;
    vic_q        <= vic_d;
    vst_q        <= vst_d;
    vlive_q      <= vlive_d;
    rkey_q       <= rkey_d;
    if (out_load) begin
      o_status_q  <= status_q;
      o_pb_q      <= pb_q;
      o_ps_q      <= ps_q;
      o_dropped_q <= dropped_q;
      o_rel_q     <= rel_q;
      o_ers_q     <= ers_q;
      o_host_q    <= host_cnt_q;
      o_relp_q    <= rel_cnt_q;
      o_erase_q   <= ers_cnt_q;
    end
  end

endmodule

// ----- rtl/pmftl_chk.sv -----
module pmftl_chk import pmftl_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic             rsp_status_i,
  input logic [BlkW-1:0]  rsp_block_i,
  input logic [SlotW-1:0] rsp_slot_i,
  input logic [RelW-1:0]  rsp_rel_i,
  input logic [ErsW-1:0]  rsp_ers_i,
  input logic [CntW-1:0]  rsp_erase_total_i
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_block_i) &&
    $stable(rsp_slot_i) && $stable(rsp_erase_total_i))
    else $error("stalled result changed");

  // Exhausted items place nothing
  a_exh_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == StatusExhausted) |->
    (rsp_block_i == '0) && (rsp_slot_i == '0))
    else $error("exhausted result carries a placement");

  // Relocation only happens inside a collection that erases
  a_rel_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_rel_i != '0) |-> (rsp_ers_i != '0))
    else $error("pages relocated without an erase");

  // Erases in an item show in the running total
  a_ers_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_ers_i != '0) |-> (rsp_erase_total_i != '0))
    else $error("erase total lags item erases");

endmodule

bind page_mapped_ftl_greedy_gc_unit pmftl_chk u_pmftl_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_block_i       (rsp_o.placed_block),
  .rsp_slot_i        (rsp_o.placed_slot),
  .rsp_rel_i         (rsp_o.pages_relocated),
  .rsp_ers_i         (rsp_o.blocks_erased),
  .rsp_erase_total_i (rsp_o.erase_total)
);
